>>> hw/rtl/rotate_vector_about_axis_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotate-about-axis block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROTATE_VECTOR_ABOUT_AXIS_TOP_ASSERT_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_TOP_ASSERT_SVH

// Same-cycle implication.
`define RVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rva_pkg.sv
// ----------------------------------------------------------------------------
// rva_pkg
// Types, constants and helper functions for the rotate-about-axis block.
// ----------------------------------------------------------------------------
package rva_pkg;

  typedef logic signed [31:0] comp_t;   // vector component
  typedef logic signed [31:0] unit_t;   // Q2.30, within [-1, 1]
  typedef logic signed [33:0] part_t;   // rounded partial sums in vector units

  localparam int ISQRT_LAT = 37;        // 5 normalize steps + 32 root steps
  localparam int DIV_LAT   = 33;        // numerator, 31 quotient bits, sign
  localparam int LANE_LAT  = 7;

  localparam logic signed [30:0] PI_Q28         = 31'sd843314857;
  localparam logic signed [32:0] PI_Q30         = 33'sd3373259426;
  localparam logic signed [32:0] HALF_PI_Q30    = 33'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30        = 33'sd1073741824;
  localparam logic signed [35:0] PART_LIMIT     = 36'sd4294967295;

  // atan(2^-i) in Q2.30, rounded half up
  function automatic logic signed [32:0] atan_q30(input int i);
    unique case (i)
      0:       atan_q30 = 33'sd843314857;
      1:       atan_q30 = 33'sd497837829;
      2:       atan_q30 = 33'sd263043837;
      3:       atan_q30 = 33'sd133525159;
      4:       atan_q30 = 33'sd67021687;
      5:       atan_q30 = 33'sd33543516;
      6:       atan_q30 = 33'sd16775851;
      7:       atan_q30 = 33'sd8388437;
      8:       atan_q30 = 33'sd4194283;
      9:       atan_q30 = 33'sd2097149;
      10:      atan_q30 = 33'sd1048576;
      11:      atan_q30 = 33'sd524288;
      default: atan_q30 = 33'sd1 <<< (30 - i);
    endcase
  endfunction

  // add half, shift right 30 with floor
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    rnd30 = t[65:30];
  endfunction

  function automatic unit_t clip_unit(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = v;
    if (v > ONE_Q30) t = ONE_Q30;
    else if (v < -ONE_Q30) t = -ONE_Q30;
    clip_unit = t[31:0];
  endfunction

  function automatic logic signed [32:0] clip_part(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v;
    if (v > PART_LIMIT) t = PART_LIMIT;
    else if (v < -PART_LIMIT) t = -PART_LIMIT;
    clip_part = t[32:0];
  endfunction

endpackage

>>> hw/rtl/rva_cordic.sv
// ----------------------------------------------------------------------------
// rva_cordic
// Pipelined rotation-mode CORDIC, one step per stage, then sign and clip.
// ----------------------------------------------------------------------------
module rva_cordic import rva_pkg::*; #(
  parameter int TRIG_STEPS = 24
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [32:0] z_in,
  input  logic               neg_in,
  output unit_t              cos_out,
  output unit_t              sin_out
);

  logic signed [32:0] x_r [TRIG_STEPS];
  logic signed [32:0] y_r [TRIG_STEPS];
  logic signed [32:0] z_r [TRIG_STEPS];
  logic               n_r [TRIG_STEPS];
  unit_t              cos_r, sin_r;

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
    logic signed [32:0] xs, ys, zs;
    logic               ns;
    if (i == 0) begin : g_first
      assign xs = CORDIC_GAIN;
      assign ys = '0;
      assign zs = z_in;
      assign ns = neg_in;
    end else begin : g_next
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
      assign ns = n_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (zs >= 0) begin
          x_r[i] <= xs - (ys >>> i);
          y_r[i] <= ys + (xs >>> i);
          z_r[i] <= zs - atan_q30(i);
        end else begin
          x_r[i] <= xs + (ys >>> i);
          y_r[i] <= ys - (xs >>> i);
          z_r[i] <= zs + atan_q30(i);
        end
        n_r[i] <= ns;
      end
    end
  end

  // fold back the half turn removed before the steps
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= clip_unit(n_r[TRIG_STEPS-1] ? -x_r[TRIG_STEPS-1] : x_r[TRIG_STEPS-1]);
      sin_r <= clip_unit(n_r[TRIG_STEPS-1] ? -y_r[TRIG_STEPS-1] : y_r[TRIG_STEPS-1]);
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

>>> hw/rtl/rva_isqrt.sv
// ----------------------------------------------------------------------------
// rva_isqrt
// Normalize a 64-bit square sum by even shifts, then a bit-pair integer
// square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rva_isqrt import rva_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] sum_in,
  output logic [31:0] root_out,
  output logic [4:0]  shift_out
);

  logic [63:0] nn_r [5];
  logic [4:0]  sh_r [5];
  logic [63:0] rem_r [32];
  logic [63:0] res_r [32];
  logic [4:0]  ss_r  [32];

  // halve the shift search each stage: 32, 16, 8, 4, 2 bits
  for (genvar j = 0; j < 5; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [63:0] ni;
    logic [4:0]  si;
    if (j == 0) begin : g_first
      assign ni = sum_in;
      assign si = '0;
    end else begin : g_next
      assign ni = nn_r[j-1];
      assign si = sh_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ni[63 -: SH] == '0) begin
          nn_r[j] <= ni << SH;
          sh_r[j] <= si | 5'(SH / 2);
        end else begin
          nn_r[j] <= ni;
          sh_r[j] <= si;
        end
      end
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] ri, qi;
    logic [4:0]  si;
    if (k == 0) begin : g_first
      assign ri = nn_r[4];
      assign qi = '0;
      assign si = sh_r[4];
    end else begin : g_next
      assign ri = rem_r[k-1];
      assign qi = res_r[k-1];
      assign si = ss_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ri >= qi + BIT) begin
          rem_r[k] <= ri - (qi + BIT);
          res_r[k] <= (qi >> 1) + BIT;
        end else begin
          rem_r[k] <= ri;
          res_r[k] <= qi >> 1;
        end
        ss_r[k] <= si;
      end
    end
  end

  assign root_out  = res_r[31][31:0];
  assign shift_out = ss_r[31];

endmodule

>>> hw/rtl/rva_div_lane.sv
// ----------------------------------------------------------------------------
// rva_div_lane
// One axis component divided by the axis length: restoring divider, one
// quotient bit per stage, then clip to one and apply the sign.
// ----------------------------------------------------------------------------
module rva_div_lane import rva_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] mag_in,
  input  logic        neg_in,
  input  logic [4:0]  shift_in,
  input  logic [31:0] root_in,
  output unit_t       u_out
);

  logic [62:0] num_r;
  logic [31:0] dv0_r;
  logic        ng0_r;
  logic [62:0] rem_r [31];
  logic [30:0] q_r   [31];
  logic [31:0] dv_r  [31];
  logic        ng_r  [31];
  unit_t       u_r;

  logic [63:0] mag_sh;
  logic [62:0] num_nxt;

  always_comb begin
    mag_sh  = {32'd0, mag_in} << shift_in;
    num_nxt = {1'b0, mag_sh[31:0], 30'd0} + {32'd0, root_in[31:1]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      dv0_r <= root_in;
      ng0_r <= neg_in;
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_bit
    localparam int J = 30 - k;
    logic [62:0] ri, dsh;
    logic [30:0] qi;
    logic [31:0] di;
    logic        ni;
    if (k == 0) begin : g_first
      assign ri = num_r;
      assign qi = '0;
      assign di = dv0_r;
      assign ni = ng0_r;
    end else begin : g_next
      assign ri = rem_r[k-1];
      assign qi = q_r[k-1];
      assign di = dv_r[k-1];
      assign ni = ng_r[k-1];
    end
    assign dsh = {31'd0, di} << J;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ri >= dsh) begin
          rem_r[k] <= ri - dsh;
          q_r[k]   <= qi | (31'd1 << J);
        end else begin
          rem_r[k] <= ri;
          q_r[k]   <= qi;
        end
        dv_r[k] <= di;
        ng_r[k] <= ni;
      end
    end
  end

  logic signed [31:0] v;

  always_comb begin
    v = (q_r[30] > 31'd1073741824) ? 32'sd1073741824 : $signed({1'b0, q_r[30]});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= ng_r[30] ? -v : v;
    end
  end

  assign u_out = u_r;

endmodule

>>> hw/rtl/rva_out_lane.sv
// ----------------------------------------------------------------------------
// rva_out_lane
// One output component: dot term, cross term, parallel and perpendicular
// parts, and the cos/sin blend of Rodrigues' formula.
// ----------------------------------------------------------------------------
module rva_out_lane import rva_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  unit_t              u_own,
  input  comp_t              p_own,
  input  unit_t              u_a,
  input  comp_t              p_b,
  input  unit_t              u_b,
  input  comp_t              p_a,
  input  unit_t              cos_in,
  input  unit_t              sin_in,
  input  part_t              d_in,
  output logic signed [63:0] dot_out,
  output comp_t              rot_out,
  output logic               sat_out
);

  logic signed [63:0] dot_r, xa_r, xb_r;
  unit_t              u1_r, u2_r, c1_r, c2_r, c3_r, c4_r, c5_r;
  unit_t              s1_r, s2_r, s3_r, s4_r, s5_r;
  comp_t              p1_r, p2_r, p3_r, p4_r;
  part_t              cr_r, cr3_r, cr4_r, par_r, par5_r, par6_r;
  logic signed [65:0] pd_r;
  logic signed [32:0] perp_r, crs_r;
  logic signed [64:0] m1_r, m2_r;
  logic signed [35:0] r_r;

  logic signed [35:0] cr_nxt, par_nxt, r_rnd;

  always_comb begin
    cr_nxt  = rnd30(66'(xa_r) - 66'(xb_r));
    par_nxt = rnd30(pd_r);
    r_rnd   = rnd30(66'(m1_r) + 66'(m2_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products
      dot_r <= u_own * p_own;
      xa_r  <= u_a * p_b;
      xb_r  <= u_b * p_a;
      u1_r  <= u_own;
      p1_r  <= p_own;
      c1_r  <= cos_in;
      s1_r  <= sin_in;
      // cross term rounded, dot merged outside
      cr_r  <= cr_nxt[33:0];
      u2_r  <= u1_r;
      p2_r  <= p1_r;
      c2_r  <= c1_r;
      s2_r  <= s1_r;
      // parallel part
      pd_r  <= u2_r * d_in;
      cr3_r <= cr_r;
      p3_r  <= p2_r;
      c3_r  <= c2_r;
      s3_r  <= s2_r;
      par_r <= par_nxt[33:0];
      cr4_r <= cr3_r;
      p4_r  <= p3_r;
      c4_r  <= c3_r;
      s4_r  <= s3_r;
      // perpendicular and cross parts, guarded
      perp_r <= clip_part(36'(p4_r) - 36'(par_r));
      crs_r  <= clip_part(36'(cr4_r));
      par5_r <= par_r;
      c5_r   <= c4_r;
      s5_r   <= s4_r;
      // blend
      m1_r   <= c5_r * perp_r;
      m2_r   <= s5_r * crs_r;
      par6_r <= par5_r;
      r_r    <= 36'(par6_r) + r_rnd;
    end
  end

  always_comb begin
    sat_out = 1'b0;
    rot_out = r_r[31:0];
    if (r_r > 36'sd2147483647) begin
      rot_out = 32'sh7fffffff;
      sat_out = 1'b1;
    end else if (r_r < -36'sd2147483648) begin
      rot_out = 32'sh80000000;
      sat_out = 1'b1;
    end
  end

  assign dot_out = dot_r;

endmodule

>>> hw/rtl/rotate_vector_about_axis_top.sv
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_top
// Rotates a Q16.16 vector anticlockwise about an arbitrary axis by a Q3.28
// angle, using a normalized axis, CORDIC sine/cosine and Rodrigues' formula.
//
// Usage:
//   Input channel in_*: one request carries vector, axis and angle; it is
//   taken on a clock edge with in_valid and in_ready both high.
//   Output channel out_*: one result per request, in request order, held
//   until out_valid and out_ready are both high.
//   Throughput: one request per cycle, sustained, while out_ready stays high.
//   The pipeline depth from acceptance to out_valid is set by the
//   bit-per-stage square root (37 stages with the shift search) and the
//   three parallel bit-per-stage dividers (33 stages) that build the unit
//   axis; CORDIC runs beside them and is delayed to meet them.
//   Stall: the whole pipeline, including the output register, holds while a
//   result waits; in_ready drops in the same cycles, so nothing is lost.
//   Reset: synchronous, active low; clears all valid flags, no data.
//   A zero axis gives a zero vector with out_zero_axis set; any component
//   clipped to 32 bits sets out_saturated.
// ----------------------------------------------------------------------------
`include "rotate_vector_about_axis_top_assert.svh"

module rotate_vector_about_axis_top import rva_pkg::*; #(
  parameter int TRIG_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic signed [30:0] in_turn_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic               out_zero_axis,
  output logic               out_saturated
);

  // stage numbers count register stages after acceptance
  localparam int ST_DIV_IN = 2 + ISQRT_LAT;
  localparam int ST_U      = ST_DIV_IN + DIV_LAT;
  localparam int ST_OUT    = ST_U + LANE_LAT + 1;
  localparam int M_DEPTH   = ST_DIV_IN - 1;
  localparam int P_DEPTH   = ST_U - 1;
  localparam int TRIG_DLY  = ST_U - (TRIG_STEPS + 2);

  // advance everything when the output register is free or being drained
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [ST_OUT-1:0] vld_r;
  logic [ST_OUT-4:0] zsh_r;   // zero-axis flag, stage 3 .. stage ST_OUT-1

  // stage 1: squares, magnitudes, folded angle
  comp_t              p1_r   [3];
  logic [63:0]        sq1_r  [3];
  logic [31:0]        mag1_r [3];
  logic [2:0]         an1_r;
  logic signed [32:0] z1_r;
  logic               tn1_r;

  comp_t              a_in [3];
  comp_t              p_in [3];
  logic signed [63:0] sq_nxt [3];
  logic signed [30:0] ang;
  logic signed [32:0] z_w, z_nxt;
  logic               tn_nxt;

  always_comb begin
    a_in[0] = in_axis_x;
    a_in[1] = in_axis_y;
    a_in[2] = in_axis_z;
    p_in[0] = in_vec_x;
    p_in[1] = in_vec_y;
    p_in[2] = in_vec_z;
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = a_in[i] * a_in[i];
    end
    ang = in_turn_angle;
    if (in_turn_angle > PI_Q28) ang = PI_Q28;
    else if (in_turn_angle < -PI_Q28) ang = -PI_Q28;
    z_w    = 33'(ang) <<< 2;
    z_nxt  = z_w;
    tn_nxt = 1'b0;
    // beyond a right angle: shift by a half turn and negate cos and sin
    if (z_w > HALF_PI_Q30) begin
      z_nxt  = z_w - PI_Q30;
      tn_nxt = 1'b1;
    end else if (z_w < -HALF_PI_Q30) begin
      z_nxt  = z_w + PI_Q30;
      tn_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]   <= p_in[i];
        sq1_r[i]  <= sq_nxt[i];
        mag1_r[i] <= a_in[i][31] ? 32'(-a_in[i]) : a_in[i];
        an1_r[i]  <= a_in[i][31];
      end
      z1_r  <= z_nxt;
      tn1_r <= tn_nxt;
    end
  end

  // stage 2: square sum; it never wraps, so zero means a zero axis
  logic [63:0] s2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  // side chains: magnitudes to the dividers, vector to the output lanes
  logic [31:0] mch_r  [M_DEPTH][3];
  logic [2:0]  anch_r [M_DEPTH];
  comp_t       pch_r  [P_DEPTH][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mch_r[0]  <= mag1_r;
      anch_r[0] <= an1_r;
      for (int k = 1; k < M_DEPTH; k++) begin
        mch_r[k]  <= mch_r[k-1];
        anch_r[k] <= anch_r[k-1];
      end
      pch_r[0] <= p1_r;
      for (int k = 1; k < P_DEPTH; k++) begin
        pch_r[k] <= pch_r[k-1];
      end
    end
  end

  // axis length and unit axis, one divider lane per component
  logic [31:0] root;
  logic [4:0]  nshift;
  unit_t       u [3];

  rva_isqrt u_isqrt (
    .clk       (clk),
    .adv       (adv),
    .sum_in    (s2_r),
    .root_out  (root),
    .shift_out (nshift)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    rva_div_lane u_div (
      .clk      (clk),
      .adv      (adv),
      .mag_in   (mch_r[M_DEPTH-1][i]),
      .neg_in   (anch_r[M_DEPTH-1][i]),
      .shift_in (nshift),
      .root_in  (root),
      .u_out    (u[i])
    );
  end

  // sine and cosine, delayed to meet the unit axis
  unit_t cos_w, sin_w;
  unit_t trc_r [TRIG_DLY];
  unit_t trs_r [TRIG_DLY];

  rva_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
    .clk     (clk),
    .adv     (adv),
    .z_in    (z1_r),
    .neg_in  (tn1_r),
    .cos_out (cos_w),
    .sin_out (sin_w)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      trc_r[0] <= cos_w;
      trs_r[0] <= sin_w;
      for (int k = 1; k < TRIG_DLY; k++) begin
        trc_r[k] <= trc_r[k-1];
        trs_r[k] <= trs_r[k-1];
      end
    end
  end

  // output lanes; the dot product merges their first products
  logic signed [63:0] dot  [3];
  comp_t              rot  [3];
  logic [2:0]         lsat;
  part_t              d_r;
  logic signed [35:0] d_nxt;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int IA = (i + 1) % 3;
    localparam int IB = (i + 2) % 3;
    rva_out_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .u_own   (u[i]),
      .p_own   (pch_r[P_DEPTH-1][i]),
      .u_a     (u[IA]),
      .p_b     (pch_r[P_DEPTH-1][IB]),
      .u_b     (u[IB]),
      .p_a     (pch_r[P_DEPTH-1][IA]),
      .cos_in  (trc_r[TRIG_DLY-1]),
      .sin_in  (trs_r[TRIG_DLY-1]),
      .d_in    (d_r),
      .dot_out (dot[i]),
      .rot_out (rot[i]),
      .sat_out (lsat[i])
    );
  end

  always_comb begin
    d_nxt = rnd30(66'(dot[0]) + 66'(dot[1]) + 66'(dot[2]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt[33:0];
    end
  end

  // valid and zero-axis flags move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_OUT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zsh_r <= {zsh_r[ST_OUT-5:0], (s2_r == 64'd0)};
    end
  end

  // output register: zero axis forces a zero result
  comp_t rx_r, ry_r, rz_r;
  logic  za_r, sat_r;
  logic  zero_w;
  assign zero_w = zsh_r[ST_OUT-4];

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r  <= zero_w ? '0 : rot[0];
      ry_r  <= zero_w ? '0 : rot[1];
      rz_r  <= zero_w ? '0 : rot[2];
      za_r  <= zero_w;
      sat_r <= !zero_w && (|lsat);
    end
  end

  assign out_valid     = vld_r[ST_OUT-1];
  assign out_rot_x     = rx_r;
  assign out_rot_y     = ry_r;
  assign out_rot_z     = rz_r;
  assign out_zero_axis = za_r;
  assign out_saturated = sat_r;

  `RVA_ASSERT_IMP(a_zero_clean, out_valid && out_zero_axis, out_rot_x == 0 && out_rot_y == 0 && out_rot_z == 0 && !out_saturated, "zero axis with nonzero result")
  `RVA_ASSERT_IMP(a_sat_at_limit, out_valid && out_saturated, out_rot_x == 32'sh7fffffff || out_rot_x == 32'sh80000000 || out_rot_y == 32'sh7fffffff || out_rot_y == 32'sh80000000 || out_rot_z == 32'sh7fffffff || out_rot_z == 32'sh80000000, "saturated flag without clipped component")
  `RVA_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_r), "pipeline moved during stall")
  `RVA_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted request missing from first stage")

endmodule
